// ----- hdl/lcps_pkg.sv -----
// lcps_pkg: shared widths, reset values, register codes and types for the
// line centroid pi steering block. Depends on nothing; every other file imports it.
package lcps_pkg;

	// sensor array
	localparam int NUM_SENSORS = 8;
	localparam int SAMPLE_W    = 8;
	localparam int POSN_W      = $clog2(NUM_SENSORS + 1);
	localparam int WD_W        = SAMPLE_W + POSN_W;
	localparam int BOT_W       = $clog2(NUM_SENSORS * 255 + 1);
	localparam int TOP_W       = $clog2(255 * NUM_SENSORS * (NUM_SENSORS + 1) / 2 + 1);

	// centroid divide, result in q4.8
	localparam int POS_FRAC  = 8;
	localparam int POS_W     = 12;
	localparam int DIVD_W    = TOP_W + POS_FRAC;
	localparam int DIV_CNT_W = $clog2(DIVD_W);
	localparam int SETP_MID  = (NUM_SENSORS + 1) * 128;

	// pi arithmetic
	localparam int GAIN_W     = 16;
	localparam int INTEG_W    = 32;
	localparam int SPEED_W    = 24;
	localparam int FRAC_SHIFT = 24;

	// configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [SAMPLE_W-1:0]     WHITE_RST = 8'd255;
	localparam logic signed [1:0]       LINE_RST  = 2'sd1;
	localparam logic [GAIN_W-1:0]       BASE_RST  = 16'd9830;
	localparam logic [GAIN_W-1:0]       KP_RST    = 16'd655;
	localparam logic [GAIN_W-1:0]       KI_RST    = 16'd328;

	typedef enum logic [2:0] {
		REG_WHITE_LEVEL,
		REG_LINE_CHOICE,
		REG_BASE_SPEED,
		REG_PROP_GAIN,
		REG_INTEG_GAIN
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MERGE,
		ST_CHECK,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_CORR,
		ST_OUT
	} state_t;

	typedef logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] dark_vec_t;
	typedef logic [NUM_SENSORS-1:0][WD_W-1:0]     wdark_vec_t;

	// step enables from the sequencer to the pi unit
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic corr_en;
	} pi_ctrl_t;

endpackage

// ----- hdl/lcps_in_if.sv -----
// lcps_in_if: request channel carrying one set of raw sensor samples.
// Depends on lcps_pkg for the sample width.
interface lcps_in_if;
	import lcps_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_0;
	logic [SAMPLE_W-1:0] sample_1;
	logic [SAMPLE_W-1:0] sample_2;
	logic [SAMPLE_W-1:0] sample_3;
	logic [SAMPLE_W-1:0] sample_4;
	logic [SAMPLE_W-1:0] sample_5;
	logic [SAMPLE_W-1:0] sample_6;
	logic [SAMPLE_W-1:0] sample_7;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3,
		output sample_4, sample_5, sample_6, sample_7,
		input  ready
	);

	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3,
		input  sample_4, sample_5, sample_6, sample_7,
		output ready
	);

endinterface

// ----- hdl/lcps_out_if.sv -----
// lcps_out_if: result channel carrying wheel speeds and line position.
// Depends on lcps_pkg for the field widths.
interface lcps_out_if;
	import lcps_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;
	logic [POS_W-1:0]          line_position;
	logic                      no_line;

	modport source (
		output valid, left_speed, right_speed, line_position, no_line,
		input  ready
	);

	modport sink (
		input  valid, left_speed, right_speed, line_position, no_line,
		output ready
	);

endinterface

// ----- hdl/lcps_lane.sv -----
// lcps_lane: one sensor lane, darkness and position-weighted darkness.
// Depends on lcps_pkg.
module lcps_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [lcps_pkg::SAMPLE_W-1:0] sample,
	input  logic [lcps_pkg::SAMPLE_W-1:0] white_level,
	input  logic [lcps_pkg::POSN_W-1:0]   weight,
	output logic [lcps_pkg::SAMPLE_W-1:0] dark_s1,
	output logic [lcps_pkg::WD_W-1:0]     wdark_s1
);
	import lcps_pkg::*;

	logic [SAMPLE_W-1:0] dark;

	// bright samples clamp to zero darkness
	assign dark = (white_level > sample) ? (white_level - sample) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			dark_s1  <= dark;
			wdark_s1 <= WD_W'(weight) * WD_W'(dark);
		end
	end

endmodule

// ----- hdl/lcps_merge.sv -----
// lcps_merge: sums the lane results into centroid numerator and denominator.
// Depends on lcps_pkg.
module lcps_merge (
	input  logic                       clk,
	input  logic                       en,
	input  lcps_pkg::dark_vec_t        dark,
	input  lcps_pkg::wdark_vec_t       wdark,
	output logic [lcps_pkg::TOP_W-1:0] top_s2,
	output logic [lcps_pkg::BOT_W-1:0] bottom_s2
);
	import lcps_pkg::*;

	logic [TOP_W-1:0] top_sum;
	logic [BOT_W-1:0] bot_sum;

	always_comb begin
		top_sum = '0;
		bot_sum = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			top_sum = top_sum + TOP_W'(wdark[i]);
			bot_sum = bot_sum + BOT_W'(dark[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s2    <= top_sum;
			bottom_s2 <= bot_sum;
		end
	end

endmodule

// ----- hdl/lcps_div.sv -----
// lcps_div: restoring divider, one quotient bit per cycle.
// Depends on lcps_pkg; divisor must be nonzero when started.
module lcps_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lcps_pkg::DIVD_W-1:0] dividend,
	input  logic [lcps_pkg::BOT_W-1:0]  divisor,
	output logic                        done,
	output logic [lcps_pkg::DIVD_W-1:0] quotient
);
	import lcps_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BOT_W-1:0]     rem_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [BOT_W:0]       trial;
	logic                 take;

	assign trial    = {rem_q, quo_q[DIVD_W-1]};
	assign take     = (trial >= {1'b0, divisor});
	assign done     = busy_q && (cnt_q == DIV_CNT_W'(DIVD_W - 1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? BOT_W'(trial - {1'b0, divisor}) : trial[BOT_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], take};
		end
	end

endmodule

// ----- hdl/lcps_pi.sv -----
// lcps_pi: error, saturating integrator, correction product and wheel speeds.
// Depends on lcps_pkg; stepped by the sequencer through pi_ctrl_t.
module lcps_pi (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lcps_pkg::pi_ctrl_t                 ctrl,
	input  logic [lcps_pkg::POS_W-1:0]         pos,
	input  logic                               no_line,
	input  logic signed [1:0]                  line_choice,
	input  logic [lcps_pkg::GAIN_W-1:0]        base_speed,
	input  logic [lcps_pkg::GAIN_W-1:0]        prop_gain,
	input  logic [lcps_pkg::GAIN_W-1:0]        integ_gain,
	output logic signed [lcps_pkg::SPEED_W-1:0] left_speed,
	output logic signed [lcps_pkg::SPEED_W-1:0] right_speed
);
	import lcps_pkg::*;

	localparam int DIFF_W  = POS_W + 2;
	localparam int EIP_W   = POS_W + GAIN_W;
	localparam int PROD_W  = INTEG_W + 1 + GAIN_W;
	localparam int DELTA_W = PROD_W - FRAC_SHIFT;
	localparam int SUM_W   = DELTA_W + 2;

	logic signed [DIFF_W-1:0]  lc_ext;
	logic signed [DIFF_W-1:0]  setp;
	logic signed [DIFF_W-1:0]  diff;
	logic [POS_W-1:0]          err;
	logic [POS_W-1:0]          err_s1;
	logic                      lt_s1;
	logic                      gt_s1;
	logic [EIP_W-1:0]          eiprod_s1;
	logic [INTEG_W-1:0]        integ_q;
	logic [INTEG_W:0]          acc_sum;
	logic [INTEG_W:0]          corr_sum;
	logic [PROD_W-1:0]         corr_prod;
	logic [DELTA_W-1:0]        delta_s2;
	logic signed [SUM_W-1:0]   base_x;
	logic signed [SUM_W-1:0]   plus;
	logic signed [SUM_W-1:0]   minus;
	logic signed [SPEED_W-1:0] base_o;
	logic signed [SPEED_W-1:0] plus_o;
	logic signed [SPEED_W-1:0] minus_o;

	function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-SPEED_W:0] hi;
		begin
			hi = v[SUM_W-1:SPEED_W-1];
			if ((hi == '0) || (hi == '1)) begin
				sat_speed = v[SPEED_W-1:0];
			end else if (v[SUM_W-1]) begin
				sat_speed = {1'b1, {(SPEED_W-1){1'b0}}};
			end else begin
				sat_speed = {1'b0, {(SPEED_W-1){1'b1}}};
			end
		end
	endfunction

	// set point is the array middle shifted by whole sensor positions
	assign lc_ext = DIFF_W'(line_choice);
	assign setp   = DIFF_W'(SETP_MID) + (lc_ext <<< POS_FRAC);
	assign diff   = $signed({2'b00, pos}) - setp;
	assign err    = diff[DIFF_W-1] ? POS_W'(-diff) : POS_W'(diff);

	assign acc_sum   = {1'b0, integ_q} + (INTEG_W + 1)'(eiprod_s1);
	assign corr_sum  = (INTEG_W + 1)'({err_s1, 16'b0}) + {1'b0, integ_q};
	assign corr_prod = PROD_W'(corr_sum) * PROD_W'(prop_gain);

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			err_s1    <= err;
			lt_s1     <= diff[DIFF_W-1];
			gt_s1     <= !diff[DIFF_W-1] && (diff != '0);
			eiprod_s1 <= EIP_W'(err) * EIP_W'(integ_gain);
		end
		if (ctrl.corr_en) begin
			delta_s2 <= corr_prod[PROD_W-1:FRAC_SHIFT];
		end
	end

	// integrator saturates at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ctrl.acc_en) begin
			integ_q <= acc_sum[INTEG_W] ? '1 : acc_sum[INTEG_W-1:0];
		end
	end

	assign base_x  = SUM_W'(base_speed);
	assign plus    = base_x + SUM_W'(delta_s2);
	assign minus   = base_x - SUM_W'(delta_s2);
	assign base_o  = SPEED_W'(base_speed);
	assign plus_o  = sat_speed(plus);
	assign minus_o = sat_speed(minus);

	always_comb begin
		left_speed  = base_o;
		right_speed = base_o;
		if (!no_line) begin
			if (lt_s1) begin
				left_speed  = plus_o;
				right_speed = minus_o;
			end else if (gt_s1) begin
				left_speed  = minus_o;
				right_speed = plus_o;
			end
		end
	end

endmodule

// ----- hdl/line_centroid_pi_steering_core.sv -----
// line_centroid_pi_steering_core: top level of the line follower steering block.
// Depends on lcps_pkg, lcps_in_if, lcps_out_if, lcps_lane, lcps_merge, lcps_div, lcps_pi.
//
// usage
//  - in_ch takes one request of eight raw sensor samples; out_ch returns one
//    result per request: left and right wheel speed, line position in q4.8
//    and a no-line flag
//  - registers sit on the apb-style port at byte addresses 0,4,8,12,16:
//    white level, line choice, base speed, kp, ki; pready is always high and
//    reads return the register value
//  - one request at a time: in_ch.ready is high only while the sequencer is
//    idle; a request with a line goes through the merge, check, the 22-step
//    centroid divider and the pi steps before it reaches the result register;
//    with no line the divide and pi steps are skipped
//  - the next request is accepted as soon as the sequencer returns to idle,
//    even while the previous result still waits in the output register
//  - when the receiver stalls, a finished result waits in the sequencer's
//    output step until the output register frees up; nothing is dropped
//  - reset clears the integrator, the sequencer and the output valid flag,
//    and loads the register defaults
//  - configuration must be written only while idle; the block does not enforce this
module line_centroid_pi_steering_core (
	input  logic                          clk,
	input  logic                          arst_n,
	lcps_in_if.sink                       in_ch,
	lcps_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lcps_pkg::PADDR_W-1:0]  paddr,
	input  logic [lcps_pkg::PDATA_W-1:0]  pwdata,
	output logic [lcps_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import lcps_pkg::*;

	// configuration registers
	logic [SAMPLE_W-1:0] white_q;
	logic signed [1:0]   line_q;
	logic [GAIN_W-1:0]   base_q;
	logic [GAIN_W-1:0]   kp_q;
	logic [GAIN_W-1:0]   ki_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;

	// sequencer
	state_t   state_q;
	state_t   state_d;
	logic     in_acc;
	logic     merge_en;
	logic     div_start;
	logic     div_done;
	logic     out_load;
	logic     no_line_q;
	pi_ctrl_t pi_ctrl;

	// datapath
	logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] samples;
	dark_vec_t         dark_s1;
	wdark_vec_t        wdark_s1;
	logic [TOP_W-1:0]  top_s2;
	logic [BOT_W-1:0]  bottom_s2;
	logic [DIVD_W-1:0] quotient;
	logic [POS_W-1:0]  pos;
	logic signed [SPEED_W-1:0] left_w;
	logic signed [SPEED_W-1:0] right_w;

	// output register
	logic                      out_valid_q;
	logic signed [SPEED_W-1:0] left_q;
	logic signed [SPEED_W-1:0] right_q;
	logic [POS_W-1:0]          pos_q;
	logic                      nl_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= WHITE_RST;
			line_q  <= LINE_RST;
			base_q  <= BASE_RST;
			kp_q    <= KP_RST;
			ki_q    <= KI_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WHITE_LEVEL: white_q <= pwdata[SAMPLE_W-1:0];
				REG_LINE_CHOICE: line_q  <= pwdata[1:0];
				REG_BASE_SPEED:  base_q  <= pwdata[GAIN_W-1:0];
				REG_PROP_GAIN:   kp_q    <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:  ki_q    <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// reads zero-extend, line choice keeps its raw two-bit code
	always_comb begin
		case (reg_idx)
			REG_WHITE_LEVEL: prdata = PDATA_W'(white_q);
			REG_LINE_CHOICE: prdata = PDATA_W'(unsigned'(line_q));
			REG_BASE_SPEED:  prdata = PDATA_W'(base_q);
			REG_PROP_GAIN:   prdata = PDATA_W'(kp_q);
			REG_INTEG_GAIN:  prdata = PDATA_W'(ki_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- lanes ----------------
	assign samples[0] = in_ch.sample_0;
	assign samples[1] = in_ch.sample_1;
	assign samples[2] = in_ch.sample_2;
	assign samples[3] = in_ch.sample_3;
	assign samples[4] = in_ch.sample_4;
	assign samples[5] = in_ch.sample_5;
	assign samples[6] = in_ch.sample_6;
	assign samples[7] = in_ch.sample_7;

	// each lane registers its darkness on the accepting edge
	for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
		lcps_lane u_lane (
			.clk         (clk),
			.en          (in_acc),
			.sample      (samples[i]),
			.white_level (white_q),
			.weight      (POSN_W'(i + 1)),
			.dark_s1     (dark_s1[i]),
			.wdark_s1    (wdark_s1[i])
		);
	end

	// ---------------- merge and centroid divide ----------------
	lcps_merge u_merge (
		.clk       (clk),
		.en        (merge_en),
		.dark      (dark_s1),
		.wdark     (wdark_s1),
		.top_s2    (top_s2),
		.bottom_s2 (bottom_s2)
	);

	// centroid = floor(256 * top / bottom)
	lcps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({top_s2, {POS_FRAC{1'b0}}}),
		.divisor  (bottom_s2),
		.done     (div_done),
		.quotient (quotient)
	);

	// saturate position to the q4.8 field
	assign pos = (quotient[DIVD_W-1:POS_W] != '0) ? '1 : quotient[POS_W-1:0];

	// ---------------- pi unit ----------------
	lcps_pi u_pi (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (pi_ctrl),
		.pos         (pos),
		.no_line     (no_line_q),
		.line_choice (line_q),
		.base_speed  (base_q),
		.prop_gain   (kp_q),
		.integ_gain  (ki_q),
		.left_speed  (left_w),
		.right_speed (right_w)
	);

	// ---------------- sequencer ----------------
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			no_line_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK) begin
				no_line_q <= (bottom_s2 == '0);
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		merge_en        = 1'b0;
		div_start       = 1'b0;
		out_load        = 1'b0;
		pi_ctrl         = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_MERGE;
			end
			ST_MERGE: begin
				merge_en = 1'b1;
				state_d  = ST_CHECK;
			end
			// zero total darkness skips the divide and holds the integrator
			ST_CHECK: begin
				if (bottom_s2 == '0) begin
					state_d = ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				pi_ctrl.mul_en = 1'b1;
				state_d        = ST_ACC;
			end
			ST_ACC: begin
				pi_ctrl.acc_en = 1'b1;
				state_d        = ST_CORR;
			end
			ST_CORR: begin
				pi_ctrl.corr_en = 1'b1;
				state_d         = ST_OUT;
			end
			// wait here while the output register is still held by the receiver
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q  <= left_w;
			right_q <= right_w;
			pos_q   <= no_line_q ? '0 : pos;
			nl_q    <= no_line_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.left_speed    = left_q;
	assign out_ch.right_speed   = right_q;
	assign out_ch.line_position = pos_q;
	assign out_ch.no_line       = nl_q;

endmodule

// ----- hdl/lcps_checker.sv -----
// lcps_checker: port-level assertions for the steering core, bound to the top.
// Depends on lcps_pkg and line_centroid_pi_steering_core.
module lcps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [lcps_pkg::SPEED_W-1:0] left_speed,
	input logic signed [lcps_pkg::SPEED_W-1:0] right_speed,
	input logic [lcps_pkg::POS_W-1:0]          line_position,
	input logic                                no_line
);
	import lcps_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(NUM_SENSORS * 256);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_speed)
			&& $stable(right_speed) && $stable(line_position) && $stable(no_line))
		else $error("stalled result changed");

	// one request in flight: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// a new result only appears after the input was closed
	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without processing");

	// no line means both wheels at base speed and a zero position
	a_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_line |-> (left_speed == right_speed) && (line_position == '0))
		else $error("no-line result inconsistent");

	// centroid never passes the last sensor
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_position <= POS_MAX)
		else $error("line position out of range");

endmodule

bind line_centroid_pi_steering_core lcps_checker u_lcps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.left_speed    (out_ch.left_speed),
	.right_speed   (out_ch.right_speed),
	.line_position (out_ch.line_position),
	.no_line       (out_ch.no_line)
);
